>>> hdl/cdf_tail_interpolator_macros.svh
// Assertion macros shared by the checker of the tail interpolator.
`ifndef CDF_TAIL_INTERPOLATOR_MACROS_SVH
`define CDF_TAIL_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define CTI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cti check failed");

// Next-cycle implication, disabled while reset is applied.
`define CTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cti check failed");

`endif

>>> hdl/cti_pkg.sv
// Shared constants and types of the tail interpolator.
`timescale 1ns / 1ps

package cti_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Field widths fixed by the interface.
  localparam int ENTRY_IDX_W = 8;
  localparam int SMP_W       = 16;
  localparam int CUM_W       = 17;
  localparam int CNT_W       = 9;

  // Q1.16 representation of one, and the reset entry count.
  localparam int PROB_ONE  = 65536;
  localparam int EIU_RESET = 256;
  localparam logic [CUM_W-1:0] CUM_ONE  = CUM_W'(PROB_ONE);
  localparam logic [CUM_W-1:0] CUM_ZERO = '0;

  // Interpolation datapath widths.
  localparam int PROD_W = CUM_W + SMP_W;
  localparam int DIV_W  = PROD_W + 1;
  localparam int QUO_W  = CUM_W;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int TAIL_W = CUM_W + 3;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_ENTRIES_IN_USE = '0;

  // Item kinds.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic [CUM_W-1:0] cumulative;
  } entry_t;

endpackage

>>> hdl/cdf_tail_interpolator.sv
// Top level: configuration register, query sequencer and interpolation datapath.
// A load item is written to the table when accepted; busy stays low and no result follows.
// A query at or below the first sample or at or above the last is answered from the end checks;
// any other query scans the table, one entry per cycle, up to the bracketing entry, then
// multiplies and divides. Results cannot stall.
// Reset is asynchronous and active low; entries_in_use resets to 256, the table is undefined.
`timescale 1ns / 1ps

module cdf_tail_interpolator
  import cti_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   action_i,
  input  logic [ENTRY_IDX_W-1:0] entry_index_i,
  input  logic [SMP_W-1:0]       entry_sample_i,
  input  logic [CUM_W-1:0]       entry_cumulative_i,
  input  logic [SMP_W-1:0]       query_sample_i,
  output logic                   done_o,
  output logic [CUM_W-1:0]       tail_probability_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_LAST  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_WAIT  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  eiu_q, eiu_d;
  logic [SMP_W-1:0]  q_q, q_d;
  logic [IDX_W-1:0]  addr_q, addr_d;
  entry_t            prev_q, prev_d;
  logic [SMP_W-1:0]  diff_q, diff_d;
  logic [SMP_W-1:0]  den_q, den_d;
  logic [CUM_W-1:0]  dmag_q, dmag_d;
  logic              dneg_q, dneg_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [CUM_W-1:0]  tail_q, tail_d;
  logic              done_q, done_d;

  logic                  accept;
  logic                  tbl_we;
  logic [IDX_W-1:0]      tbl_waddr;
  entry_t                tbl_wdata;
  logic [IDX_W-1:0]      tbl_raddr;
  entry_t                tbl_rdata;
  logic [IDX_W-1:0]      last_idx;
  logic                  cfg_write;
  logic [APB_ADDR_W-3:0] reg_index;
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic                  div_done;
  logic [QUO_W-1:0]      div_quotient;
  logic signed [CUM_W:0] delta;
  logic signed [TAIL_W-1:0] interp;
  logic signed [TAIL_W-1:0] tail_s;
  logic signed [TAIL_W-1:0] quo_s;

  assign accept = start & ~busy;
  assign busy   = (state_q != ST_IDLE);

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel & penable & pwrite & pready & (reg_index == REG_ENTRIES_IN_USE);
  assign eiu_d     = cfg_write ? pwdata[CNT_W-1:0] : eiu_q;
  assign prdata    = (reg_index == REG_ENTRIES_IN_USE) ? APB_DATA_W'(eiu_q) : '0;

  // Index of the last entry in use, with the count clamped to the table.
  always_comb begin
    if (eiu_q < CNT_W'(2)) begin
      last_idx = IDX_W'(1);
    end else if (int'(eiu_q) > TABLE_DEPTH) begin
      last_idx = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      last_idx = IDX_W'(eiu_q - CNT_W'(1));
    end
  end

  // Load items write the table at the edge that accepts them.
  assign tbl_we    = accept && (action_i == ACT_LOAD) && (int'(entry_index_i) < TABLE_DEPTH);
  assign tbl_waddr = IDX_W'(entry_index_i);
  assign tbl_wdata.sample     = entry_sample_i;
  assign tbl_wdata.cumulative = (entry_cumulative_i > CUM_ONE) ? CUM_ONE : entry_cumulative_i;

  // Read address for the data that arrives in the next state.
  always_comb begin
    unique case (state_q)
      ST_FIRST: tbl_raddr = last_idx;
      ST_LAST:  tbl_raddr = IDX_W'(1);
      ST_SCAN:  tbl_raddr = addr_q + IDX_W'(1);
      default:  tbl_raddr = '0;
    endcase
  end

  cti_table u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Rounded division: half the divisor is added to the product first.
  assign div_start    = (state_q == ST_DIV);
  assign div_dividend = {1'b0, prod_q} + DIV_W'(den_q[SMP_W-1:1]);

  cti_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // Slope of the bracketing pair and the final clamped tail value.
  assign delta  = $signed({1'b0, tbl_rdata.cumulative}) - $signed({1'b0, prev_q.cumulative});
  assign quo_s  = $signed({{(TAIL_W - QUO_W){1'b0}}, div_quotient});
  assign interp = $signed({{(TAIL_W - CUM_W){1'b0}}, prev_q.cumulative})
                  + (dneg_q ? -quo_s : quo_s);
  assign tail_s = TAIL_W'(PROB_ONE) - interp;

  // Query sequencer.
  always_comb begin
    state_d = state_q;
    q_d     = q_q;
    addr_d  = addr_q;
    prev_d  = prev_q;
    diff_d  = diff_q;
    den_d   = den_q;
    dmag_d  = dmag_q;
    dneg_d  = dneg_q;
    prod_d  = prod_q;
    tail_d  = tail_q;
    done_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (action_i == ACT_QUERY)) begin
          q_d     = query_sample_i;
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (q_q <= tbl_rdata.sample) begin
          tail_d  = CUM_ONE;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          prev_d  = tbl_rdata;
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        if (q_q >= tbl_rdata.sample) begin
          tail_d  = CUM_ZERO;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          addr_d  = IDX_W'(1);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tbl_rdata.sample < q_q) begin
          prev_d = tbl_rdata;
          addr_d = addr_q + IDX_W'(1);
        end else begin
          diff_d  = q_q - prev_q.sample;
          den_d   = tbl_rdata.sample - prev_q.sample;
          dneg_d  = delta[CUM_W];
          dmag_d  = delta[CUM_W] ? CUM_W'(-delta) : CUM_W'(delta);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = PROD_W'(dmag_q) * PROD_W'(diff_q);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          if (tail_s < 0) begin
            tail_d = CUM_ZERO;
          end else if (tail_s > TAIL_W'(PROB_ONE)) begin
            tail_d = CUM_ONE;
          end else begin
            tail_d = CUM_W'(tail_s);
          end
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      eiu_q   <= CNT_W'(EIU_RESET);
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      eiu_q   <= eiu_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    q_q    <= q_d;
    addr_q <= addr_d;
    prev_q <= prev_d;
    diff_q <= diff_d;
    den_q  <= den_d;
    dmag_q <= dmag_d;
    dneg_q <= dneg_d;
    prod_q <= prod_d;
    tail_q <= tail_d;
  end

  assign done_o             = done_q;
  assign tail_probability_o = tail_q;

endmodule

>>> hdl/cti_table.sv
// Table memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module cti_table
  import cti_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/cti_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module cti_divider
  import cti_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [SMP_W-1:0] divisor_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quotient_o
);

  logic [SMP_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [SMP_W-1:0]  dvs_q, dvs_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [SMP_W:0]    partial;
  logic              fits;

  // One trial subtraction of the divisor from the shifted remainder.
  assign partial = {rem_q, quo_q[DIV_W-1]};
  assign fits    = partial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fits ? SMP_W'(partial - {1'b0, dvs_q}) : partial[SMP_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + DCNT_W'(1);
      if (cnt_q == DCNT_W'(DIV_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  // The quotient never exceeds one in Q1.16, so its upper bits are zero.
  assign done_o     = done_q;
  assign quotient_o = quo_q[QUO_W-1:0];

endmodule

>>> hdl/cti_checker.sv
// Port-level checks of the tail interpolator and their binding to it.
`timescale 1ns / 1ps
`include "cdf_tail_interpolator_macros.svh"

module cti_checker
  import cti_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             action_i,
  input logic             done_o,
  input logic [CUM_W-1:0] tail_probability_o
);

  logic load_acc;
  logic query_acc;

  assign load_acc  = start && !busy && (action_i == ACT_LOAD);
  assign query_acc = start && !busy && (action_i == ACT_QUERY);

  // A result never exceeds one.
  `CTI_ASSERT_NOW(a_tail_range, clk_i, rst_ni, done_o, tail_probability_o <= CUM_ONE)
  // The block is free again while a result is shown.
  `CTI_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy)
  // Two results never come in adjacent cycles.
  `CTI_ASSERT_NEXT(a_done_gap, clk_i, rst_ni, done_o, !done_o)
  // A load item neither occupies the block nor gives a result.
  `CTI_ASSERT_NEXT(a_load_quiet, clk_i, rst_ni, load_acc, !busy && !done_o)
  // A query item occupies the block in the next cycle.
  `CTI_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, query_acc, busy && !done_o)

endmodule

bind cdf_tail_interpolator cti_checker u_cti_checker (.*);

>>> verif/cdf_tail_interpolator_test.sv
// Self-checking testbench of the cumulative-table tail interpolator.
`timescale 1ns / 1ps

module cdf_tail_interpolator_test;
  import cti_pkg::*;

  localparam int unsigned ITEM_TARGET = 1150;
  localparam int unsigned LOAD_DRAIN  = 4;
  localparam int unsigned QUERY_DRAIN = 300;

  // Keeps its own copy of the table and the entry count, predicts the tail
  // probability of every accepted query and checks the results in order.
  class tail_tracker;
    logic [SMP_W-1:0] samples [TABLE_DEPTH];
    logic [CUM_W-1:0] cumulatives [TABLE_DEPTH];
    int unsigned      entries_in_use;
    logic [CUM_W-1:0] expected_tails [$];
    int unsigned      mismatches;

    function new();
      entries_in_use = EIU_RESET;
      mismatches = 0;
      foreach (samples[k]) begin
        samples[k] = '0;
        cumulatives[k] = '0;
      end
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch %0d at %0t: %s", mismatches, $realtime, msg);
    endtask

    // Out-of-range counts are pulled back into 2..TABLE_DEPTH.
    function int unsigned active_count();
      int unsigned n;
      n = entries_in_use;
      if (n < 2) n = 2;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      return n;
    endfunction

    function void set_entries(logic [APB_DATA_W-1:0] value);
      entries_in_use = value[CNT_W-1:0];
    endfunction

    // One minus the interpolated cumulative value, rounded half away from zero.
    function logic [CUM_W-1:0] predict_tail(logic [SMP_W-1:0] q);
      int unsigned n;
      int unsigned i;
      longint s0, s1, a0, a1, num, den, mag, quo, p;
      n = active_count();
      if (q <= samples[0]) return CUM_ONE;
      if (q >= samples[n-1]) return CUM_ZERO;
      i = 1;
      while (i < n && samples[i] < q) i++;
      if (i >= n) i = n - 1;
      s0 = samples[i-1];
      s1 = samples[i];
      a0 = cumulatives[i-1];
      a1 = cumulatives[i];
      num = (a1 - a0) * (longint'(q) - s0);
      den = s1 - s0;
      if (den <= 0) den = 1;
      mag = (num < 0) ? -num : num;
      quo = (mag + den / 2) / den;
      if (num < 0) quo = -quo;
      p = longint'(PROB_ONE) - (a0 + quo);
      if (p < 0) p = 0;
      if (p > PROB_ONE) p = PROB_ONE;
      return CUM_W'(p);
    endfunction

    function void note_item(logic act, logic [ENTRY_IDX_W-1:0] idx, logic [SMP_W-1:0] smp,
                            logic [CUM_W-1:0] cum, logic [SMP_W-1:0] q);
      if (act == ACT_LOAD) begin
        if (idx < TABLE_DEPTH) begin
          if (cum > CUM_ONE) cum = CUM_ONE;
          samples[idx] = smp;
          cumulatives[idx] = cum;
        end
      end else begin
        expected_tails = {expected_tails, predict_tail(q)};
      end
    endfunction

    task check_tail(logic [CUM_W-1:0] got);
      logic [CUM_W-1:0] want;
      if (expected_tails.size() == 0) begin
        report($sformatf("tail_probability %0d with no query outstanding", got));
      end else begin
        want = expected_tails.pop_front();
        if (got !== want) report($sformatf("tail_probability %0d, predicted %0d", got, want));
      end
    endtask

    task close_out();
      if (expected_tails.size() != 0)
        report($sformatf("%0d query results never arrived", expected_tails.size()));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   action_i = ACT_LOAD;
  logic [ENTRY_IDX_W-1:0] entry_index_i = '0;
  logic [SMP_W-1:0]       entry_sample_i = '0;
  logic [CUM_W-1:0]       entry_cumulative_i = '0;
  logic [SMP_W-1:0]       query_sample_i = '0;
  logic                   done_o;
  logic [CUM_W-1:0]       tail_probability_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  tail_tracker tail_sb = new();
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned table_filled = 0;

  cdf_tail_interpolator dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Results cannot be held off, so every strobe is checked as it comes.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) tail_sb.check_tail(tail_probability_o);
  end

  // Sender gaps: mostly short, sometimes long enough to cover a full scan.
  task automatic pace();
    int unsigned r;
    int unsigned g;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      g = (r < 70) ? $urandom_range(1, 4) : (r < 90) ? $urandom_range(5, 40)
                                                    : $urandom_range(41, 300);
      start <= 1'b0;
      action_i <= 1'($urandom);
      entry_index_i <= ENTRY_IDX_W'($urandom);
      entry_sample_i <= SMP_W'($urandom);
      entry_cumulative_i <= CUM_W'($urandom);
      query_sample_i <= SMP_W'($urandom);
      repeat (g) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(20, 60);
    end
  endtask

  // Presents one item and holds it until start meets a low busy.
  task automatic send_item(logic act, logic [ENTRY_IDX_W-1:0] idx, logic [SMP_W-1:0] smp,
                           logic [CUM_W-1:0] cum, logic [SMP_W-1:0] q);
    start <= 1'b1;
    action_i <= act;
    entry_index_i <= idx;
    entry_sample_i <= smp;
    entry_cumulative_i <= cum;
    query_sample_i <= q;
    do @(posedge clk_i); while (busy !== 1'b0);
    tail_sb.note_item(act, idx, smp, cum, q);
    items_sent++;
    pace();
  endtask

  task automatic load_entry(int unsigned idx, int unsigned smp, int unsigned cum);
    send_item(ACT_LOAD, ENTRY_IDX_W'(idx), SMP_W'(smp), CUM_W'(cum), SMP_W'($urandom));
  endtask

  task automatic ask(int unsigned q);
    send_item(ACT_QUERY, ENTRY_IDX_W'($urandom), SMP_W'($urandom), CUM_W'($urandom), SMP_W'(q));
  endtask

  // Waits until every query has answered, then lets a trailing load finish.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (tail_sb.expected_tails.size() != 0 || busy !== 1'b0);
    repeat (LOAD_DRAIN) @(posedge clk_i);
  endtask

  // A setup phase, an access phase held until pready, then the port is released.
  task automatic apb_access(logic wr, logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {REG_ENTRIES_IN_USE, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    if (wr) tail_sb.set_entries(wdata);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes the entry count with junk in the unused upper bits, then reads it back.
  task automatic write_count(int unsigned count);
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b1, {(APB_DATA_W-CNT_W)'($urandom), CNT_W'(count)}, rd);
    apb_access(1'b0, APB_DATA_W'($urandom), rd);
    if (rd[CNT_W-1:0] !== CNT_W'(count))
      tail_sb.report($sformatf("entries_in_use reads %0d, written %0d", rd[CNT_W-1:0], count));
  endtask

  function automatic int unsigned pick_setting(int unsigned phase);
    case (phase)
      0: return TABLE_DEPTH;
      1: return 511;
      2: return 300;
      3: return 0;
      4: return 1;
      5: return 2;
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(25, TABLE_DEPTH)
                                                  : $urandom_range(2, 24);
    endcase
  endfunction

  // Queries land mostly inside the table, some on or next to a sample, some anywhere.
  function automatic int unsigned pick_query(int unsigned n);
    int unsigned lo, hi, tmp, r;
    lo = tail_sb.samples[0];
    hi = tail_sb.samples[n-1];
    if (lo > hi) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 65535);
    if (r < 25) return SMP_W'(tail_sb.samples[$urandom_range(0, n-1)] + $urandom_range(0, 2) - 1);
    return $urandom_range(lo, hi);
  endfunction

  // A random phase: new count, an ascending table where needed, then mostly
  // queries with the odd entry overwritten by random content.
  task automatic run_phase(int unsigned phase);
    int unsigned n, m, k, base, gapmax, smp, cum, cstep;
    write_count(pick_setting(phase));
    n = tail_sb.active_count();
    if (n <= 64 || table_filled < n) begin
      base = $urandom_range(0, 4000);
      gapmax = (65535 - base) / (n - 1);
      smp = base;
      cum = $urandom_range(0, 3000);
      cstep = (PROB_ONE - cum) / (n - 1);
      for (k = 0; k < n; k++) begin
        load_entry(k, smp, ($urandom_range(0, 15) == 0) ? $urandom_range(PROB_ONE, 131071) : cum);
        smp += $urandom_range(1, gapmax);
        cum += $urandom_range(0, cstep);
      end
      if (table_filled < n) table_filled = n;
    end
    m = $urandom_range(30, 80);
    repeat (m) begin
      if ($urandom_range(0, 99) < 88) ask(pick_query(n));
      else load_entry($urandom_range(0, n-1), $urandom_range(0, 65535), $urandom_range(0, 131071));
    end
    settle();
  endtask

  initial begin
    int unsigned phase;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Count below two, a two-entry table spanning the whole sample range,
    // a cumulative value above one, and queries at both ends.
    write_count(0);
    load_entry(0, 0, 0);
    load_entry(1, 65535, 131071);
    ask(0);
    ask(65535);
    ask(1);
    ask(32768);
    ask(65534);
    settle();

    // A rounding tie with a falling cumulative pair, then a rising cumulative pair.
    write_count(1);
    load_entry(0, 10, 1);
    load_entry(1, 12, 0);
    ask(11);
    load_entry(1, 12, 2);
    ask(11);
    settle();

    // Four entries, neither samples nor cumulative values in order.
    write_count(4);
    load_entry(0, 1000, PROB_ONE);
    load_entry(1, 3000, 0);
    load_entry(2, 2000, 40000);
    load_entry(3, 60000, 65535);
    ask(1000);
    ask(2500);
    ask(3000);
    ask(4000);
    ask(60000);
    ask(59999);
    settle();
    table_filled = 4;

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      run_phase(phase);
      phase++;
    end

    settle();
    repeat (QUERY_DRAIN) @(posedge clk_i);
    tail_sb.close_out();
    if (tail_sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest legal run.
  initial begin
    #(30_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
